// ===== hw/rtl/psfum_pkg.sv =====
// Shared types, codes and helpers of the PSF2 Unicode glyph map.
package psfum_pkg;

   // Kind of a request transaction, carried in req_tuser
   typedef enum logic [1:0] {
      MODE_LOAD    = 2'd0,
      MODE_UNICODE = 2'd1,
      MODE_DIRECT  = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   // Register indexes on the csr port (paddr[2])
   localparam logic CSR_GLYPH_COUNT = 1'b0;
   localparam logic CSR_HAS_TABLE   = 1'b1;

   localparam int CP_W     = 21;
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 10;
   localparam int OUT_IDX_W = 9;

   localparam logic [COUNT_W-1:0] GLYPH_COUNT_RST = 10'd256;
   localparam logic [CP_W-1:0] MAX_UNICODE     = 21'h10FFFF;
   localparam logic [CP_W-1:0] SURROGATE_MASK  = 21'h1FF800;
   localparam logic [CP_W-1:0] SURROGATE_BASE  = 21'h00D800;
   localparam logic [CP_W-1:0] PRINT_LO        = 21'h000020;
   localparam logic [CP_W-1:0] PRINT_HI        = 21'h00007E;
   localparam logic [BYTE_W-1:0] NEXT_GLYPH    = 8'hFF;

   // Lookup request handed from the front end to the lookup stage
   typedef struct packed {
      logic            unicode;
      logic [CP_W-1:0] cp;
      logic            loaded;
   } lkp_req_type;

   // True for a scalar value that is neither a surrogate nor past the Unicode range
   function automatic logic in_unicode_range(input logic [CP_W-1:0] cp);
      in_unicode_range = (cp <= MAX_UNICODE) && ((cp & SURROGATE_MASK) != SURROGATE_BASE);
   endfunction

endpackage

// ===== hw/rtl/psfum_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module psfum_ram
   #(
      parameter int WIDTH = 9,
      parameter int DEPTH = 65536
   )
   (
      input  logic                     clock,
      input  logic                     wr_en,
      input  logic [$clog2(DEPTH)-1:0] wr_addr,
      input  logic [WIDTH-1:0]         wr_data,
      input  logic                     rd_en,
      input  logic [$clog2(DEPTH)-1:0] rd_addr,
      output logic [WIDTH-1:0]         rd_data
   );

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/psfum_utf8_decoder.sv =====
// UTF-8 decoder of the table load path: assembles code points and issues map writes.
module psfum_utf8_decoder
   import psfum_pkg::*;
   #(
      parameter int CODE_BITS  = 16,
      parameter int GLYPH_BITS = 9
   )
   (
      input  logic                  clock,
      input  logic                  reset,
      input  logic                  en,
      input  logic [BYTE_W-1:0]     data_byte,
      input  logic                  has_table,
      input  logic [COUNT_W-1:0]    eff_count,
      output logic                  done,
      output logic                  wr_en,
      output logic [CODE_BITS-1:0]  wr_addr,
      output logic [GLYPH_BITS-1:0] wr_data
   );

   logic [CP_W-1:0]    acc_ff, acc_in;
   logic [1:0]         pend_ff, pend_in;
   logic [COUNT_W-1:0] cur_ff, cur_in;
   logic [CP_W-1:0]    cand;
   logic [CP_W-1:0]    shifted;
   logic               store_try;
   logic [GLYPH_BITS+COUNT_W-1:0] cur_ext;

   assign done    = (cur_ff >= eff_count);
   assign shifted = {acc_ff[CP_W-7:0], data_byte[5:0]};

   always_comb begin
      acc_in    = acc_ff;
      pend_in   = pend_ff;
      cur_in    = cur_ff;
      cand      = shifted;
      store_try = 1'b0;
      if (en && has_table && !done) begin
         priority if (data_byte == NEXT_GLYPH) begin
            acc_in  = '0;
            pend_in = 2'd0;
            cur_in  = cur_ff + 10'd1;
         end else if (!data_byte[7]) begin
            acc_in    = '0;
            pend_in   = 2'd0;
            cand      = {13'd0, data_byte};
            store_try = 1'b1;
         end else if (data_byte[7:6] == 2'b10) begin
            if (pend_ff != 2'd0) begin
               acc_in  = shifted;
               pend_in = pend_ff - 2'd1;
               if (pend_ff == 2'd1) begin
                  store_try = 1'b1;
                  acc_in    = '0;
               end
            end
         end else if (data_byte[7:5] == 3'b110) begin
            acc_in  = {16'd0, data_byte[4:0]};
            pend_in = 2'd1;
         end else if (data_byte[7:4] == 4'b1110) begin
            acc_in  = {17'd0, data_byte[3:0]};
            pend_in = 2'd2;
         end else if (data_byte[7:3] == 5'b11110) begin
            acc_in  = {18'd0, data_byte[2:0]};
            pend_in = 2'd3;
         end else begin
            // invalid lead byte: drop any partial character
            acc_in  = '0;
            pend_in = 2'd0;
         end
      end
   end

   assign cur_ext = {{GLYPH_BITS{1'b0}}, cur_ff};
   assign wr_en   = store_try && (cand != '0) && in_unicode_range(cand)
                    && ((cand >> CODE_BITS) == '0);
   assign wr_addr = cand[CODE_BITS-1:0];
   assign wr_data = cur_ext[GLYPH_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= 2'd0;
         cur_ff  <= '0;
      end else begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
         cur_ff  <= cur_in;
      end
   end

   a_idle_acc_clear: assert property (@(posedge clock) disable iff (reset)
      (pend_ff == 2'd0) |-> (acc_ff == '0))
      else $error("accumulator holds bits with no character pending");

   a_glyph_only_on_load: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(cur_ff))
      else $error("glyph number moved without a table byte");

endmodule

// ===== hw/rtl/psfum_lookup.sv =====
// Lookup stage: combines map read data with range checks and holds the response register.
module psfum_lookup
   import psfum_pkg::*;
   #(
      parameter int CODE_BITS  = 16,
      parameter int GLYPH_BITS = 9
   )
   (
      input  logic                  clock,
      input  logic                  reset,
      input  logic                  start,
      input  lkp_req_type           req,
      input  logic [GLYPH_BITS-1:0] ram_q,
      input  logic                  has_table,
      input  logic [COUNT_W-1:0]    eff_count,
      output logic                  ready,
      output logic                  rsp_valid,
      input  logic                  rsp_ready,
      output logic [OUT_IDX_W-1:0]  glyph_index,
      output logic                  table_loaded
   );

   logic                 s1_valid_ff, s1_valid_in;
   lkp_req_type          s1_req_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0] rsp_glyph_ff;
   logic                 rsp_loaded_ff;
   logic                 out_free;
   logic                 reject;
   logic [CP_W-1:0]      idx;
   logic [CP_W-1:0]      idx_ok;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign ready    = !s1_valid_ff || out_free;

   assign reject = !in_unicode_range(s1_req_ff.cp) || ((s1_req_ff.cp >> CODE_BITS) != '0);

   always_comb begin
      if (!s1_req_ff.unicode) begin
         idx = s1_req_ff.cp;
      end else if (!has_table) begin
         idx = (s1_req_ff.cp >= PRINT_LO && s1_req_ff.cp <= PRINT_HI) ? s1_req_ff.cp : '0;
      end else begin
         idx = reject ? '0 : CP_W'(ram_q);
      end
      idx_ok = (idx >= CP_W'(eff_count)) ? '0 : idx;
   end

   assign s1_valid_in  = ready ? start : s1_valid_ff;
   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && ready) begin
         s1_req_ff <= req;
      end
      if (s1_valid_ff && out_free) begin
         rsp_glyph_ff  <= idx_ok[OUT_IDX_W-1:0];
         rsp_loaded_ff <= s1_req_ff.loaded;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign glyph_index  = rsp_glyph_ff;
   assign table_loaded = rsp_loaded_ff;

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free) |=> s1_valid_ff)
      else $error("pending lookup lost while response stalled");

endmodule

// ===== hw/rtl/psf2_unicode_glyph_map.sv =====
// Top level of the PSF2 Unicode glyph map: csr port, map clearing, load and lookup paths.
// A lookup is registered in the lookup stage and then in the response register behind rsp_tvalid.
// Throughput: one transaction per cycle; the map RAM takes one write (load) or one
// read (lookup) per cycle, and a stalled response holds the lookup stage.
// Reset (synchronous, active high) clears the decoder and handshake state, then sweeps the
// map RAM to zero at every entry with req_tready low; csr writes are taken as usual.
module psf2_unicode_glyph_map
   import psfum_pkg::*;
   #(
      parameter int CODE_BITS  = 16,
      parameter int GLYPH_BITS = 9
   )
   (
      input  logic        clock,
      input  logic        reset,
      // request channel
      input  logic        req_tvalid,
      output logic        req_tready,
      input  logic [31:0] req_tdata,   // [7:0] data_byte, [28:8] code_point, [31:29] zero
      input  logic [1:0]  req_tuser,   // [1:0] mode
      // response channel
      output logic        rsp_tvalid,
      input  logic        rsp_tready,
      output logic [15:0] rsp_tdata,   // [8:0] glyph_index, [9] table_loaded, [15:10] zero
      // configuration port
      input  logic        csr_psel,
      input  logic        csr_penable,
      input  logic        csr_pwrite,
      input  logic [2:0]  csr_paddr,
      input  logic [31:0] csr_pwdata,
      output logic [31:0] csr_prdata,
      output logic        csr_pready
   );

   localparam int LIM = 1 << GLYPH_BITS;

   // configuration registers
   logic [COUNT_W-1:0] glyph_count_ff;
   logic               has_table_ff;
   logic [COUNT_W-1:0] eff_count;
   logic               csr_wr;

   // clearing sweep
   logic                 clear_ff, clear_in;
   logic [CODE_BITS-1:0] clr_addr_ff, clr_addr_in;

   // request decode
   mode_type           req_mode;
   logic [BYTE_W-1:0]  req_byte;
   logic [CP_W-1:0]    req_cp;
   logic               accept;
   logic               lkp_ready;
   logic               lkp_start;
   lkp_req_type        lkp_req;

   // decoder and RAM
   logic                  dec_done;
   logic                  dec_wr_en;
   logic [CODE_BITS-1:0]  dec_wr_addr;
   logic [GLYPH_BITS-1:0] dec_wr_data;
   logic                  ram_wr_en;
   logic [CODE_BITS-1:0]  ram_wr_addr;
   logic [GLYPH_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [GLYPH_BITS-1:0] ram_q;

   logic [OUT_IDX_W-1:0] rsp_glyph;
   logic                 rsp_loaded;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         glyph_count_ff <= GLYPH_COUNT_RST;
         has_table_ff   <= 1'b1;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_GLYPH_COUNT: glyph_count_ff <= csr_pwdata[COUNT_W-1:0];
            CSR_HAS_TABLE:   has_table_ff   <= csr_pwdata[0];
            default:         has_table_ff   <= has_table_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_GLYPH_COUNT: csr_prdata = {22'd0, glyph_count_ff};
         CSR_HAS_TABLE:   csr_prdata = {31'd0, has_table_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Effective glyph count: the programmed count, capped at what a map entry can hold.
   assign eff_count = (GLYPH_BITS >= COUNT_W || glyph_count_ff < COUNT_W'(LIM)) ?
                      glyph_count_ff : COUNT_W'(LIM);

   // ---------------- clearing sweep after reset ----------------
   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + CODE_BITS'(1);
         if (clr_addr_ff == '1) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ---------------- request front end ----------------
   assign req_mode = mode_type'(req_tuser);
   assign req_byte = req_tdata[7:0];
   assign req_cp   = req_tdata[28:8];

   // Hold requests off during the sweep and while the lookup stage is blocked.
   assign req_tready = !clear_ff && lkp_ready;
   assign accept     = req_tvalid && req_tready;
   assign lkp_start  = accept && (req_mode == MODE_UNICODE || req_mode == MODE_DIRECT);

   // Capture the load status at accept so later table bytes cannot change it.
   assign lkp_req.unicode = (req_mode == MODE_UNICODE);
   assign lkp_req.cp      = req_cp;
   assign lkp_req.loaded  = !has_table_ff || dec_done;

   psfum_utf8_decoder #(
      .CODE_BITS  (CODE_BITS),
      .GLYPH_BITS (GLYPH_BITS)
   ) u_decoder (
      .clock     (clock),
      .reset     (reset),
      .en        (accept && (req_mode == MODE_LOAD)),
      .data_byte (req_byte),
      .has_table (has_table_ff),
      .eff_count (eff_count),
      .done      (dec_done),
      .wr_en     (dec_wr_en),
      .wr_addr   (dec_wr_addr),
      .wr_data   (dec_wr_data)
   );

   // The sweep owns the write port until it ends; no load can be accepted meanwhile.
   assign ram_wr_en   = clear_ff || dec_wr_en;
   assign ram_wr_addr = clear_ff ? clr_addr_ff : dec_wr_addr;
   assign ram_wr_data = clear_ff ? '0 : dec_wr_data;
   // Read only for a Unicode lookup; read data then holds through a stall.
   assign ram_rd_en   = accept && (req_mode == MODE_UNICODE);

   psfum_ram #(
      .WIDTH (GLYPH_BITS),
      .DEPTH (1 << CODE_BITS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_cp[CODE_BITS-1:0]),
      .rd_data (ram_q)
   );

   psfum_lookup #(
      .CODE_BITS  (CODE_BITS),
      .GLYPH_BITS (GLYPH_BITS)
   ) u_lookup (
      .clock        (clock),
      .reset        (reset),
      .start        (lkp_start),
      .req          (lkp_req),
      .ram_q        (ram_q),
      .has_table    (has_table_ff),
      .eff_count    (eff_count),
      .ready        (lkp_ready),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .glyph_index  (rsp_glyph),
      .table_loaded (rsp_loaded)
   );

   assign rsp_tdata = {6'd0, rsp_loaded, rsp_glyph};

   a_no_accept_in_sweep: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_tready)
      else $error("request taken while the map is being cleared");

   a_sweep_covers_all: assert property (@(posedge clock) disable iff (reset)
      $fell(clear_ff) |-> (clr_addr_ff == '0))
      else $error("clearing sweep ended before covering every entry");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the PSF2 glyph map: phased table loads and lookups checked live.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import psfum_pkg::*;

   // Match the block's default sizing; the shadow table below relies on it
   localparam int CODE_BITS  = 16;
   localparam int GLYPH_BITS = 9;
   localparam int MAP_DEPTH  = 1 << CODE_BITS;
   localparam int MAX_PRINTS = 40;

   // One request transaction as the bench sees it
   typedef struct {
      mode_type    mode;
      logic [7:0]  data_byte;
      logic [20:0] code_point;
   } glyph_req_type;

   // One lookup response: glyph index and the table-loaded flag
   typedef struct {
      logic [8:0] glyph;
      logic       loaded;
   } glyph_rsp_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = '0;   // [7:0] data_byte, [28:8] code_point, [31:29] zero
   logic [1:0]  req_tuser   = '0;   // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;          // [8:0] glyph_index, [9] table_loaded, [15:10] zero
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   psf2_unicode_glyph_map #(
      .CODE_BITS  (CODE_BITS),
      .GLYPH_BITS (GLYPH_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Shadow copy of the glyph map: the table itself, the UTF-8 decoder state,
   // the glyph being filled and the two registers as last written.
   // ---------------------------------------------------------------------------
   logic [8:0]  glyph_of_cp [MAP_DEPTH];
   logic [20:0] utf_acc         = '0;
   logic [1:0]  utf_left        = '0;
   logic [9:0]  cur_glyph       = '0;
   logic [9:0]  cfg_glyph_count = GLYPH_COUNT_RST;
   logic        cfg_has_table   = 1'b1;

   glyph_req_type pending_req [$];   // stimulus not yet handed to the driver
   glyph_rsp_type glyph_rsp_due [$]; // lookups accepted, response still outstanding
   logic [20:0]   recent_cp [$];     // code points recently sent in table loads

   int unsigned pushed    = 0;
   int unsigned n_accept  = 0;
   int unsigned n_loads   = 0;
   int unsigned n_checked = 0;
   int unsigned errors    = 0;

   // Glyph slots in use: the register clipped to what the index width can hold
   function automatic int unsigned usable_glyphs();
      return (cfg_glyph_count < (1 << GLYPH_BITS)) ? cfg_glyph_count : (1 << GLYPH_BITS);
   endfunction

   // Record a decoded code point against the glyph being filled, unless it can't be stored
   function automatic void keep_code(input logic [20:0] cp);
      if (cp != 0 && cp <= MAX_UNICODE && !(cp >= 21'hD800 && cp <= 21'hDFFF)
          && cp < MAP_DEPTH)
         glyph_of_cp[cp[CODE_BITS-1:0]] = cur_glyph[8:0];
   endfunction

   // Advance the shadow map by one accepted request and queue the response it owes
   function automatic void track_glyph_map(input glyph_req_type it);
      int unsigned   lim;
      int unsigned   idx;
      logic [7:0]    b;
      glyph_rsp_type w;
      lim = usable_glyphs();
      b   = it.data_byte;
      case (it.mode)
         MODE_LOAD: begin
            n_loads++;
            // Drop table bytes when no table is in use or every glyph is filled
            if (cfg_has_table && cur_glyph < lim) begin
               if (b == NEXT_GLYPH) begin
                  utf_left  = '0;
                  utf_acc   = '0;
                  cur_glyph = cur_glyph + 10'd1;
               end else if (b < 8'h80) begin
                  // plain ASCII also abandons any half-decoded character
                  utf_left = '0;
                  utf_acc  = '0;
                  keep_code({13'd0, b});
               end else if (b[7:6] == 2'b10) begin
                  // continuation; stray ones with nothing pending fall through
                  if (utf_left != 0) begin
                     utf_acc  = {utf_acc[14:0], b[5:0]};
                     utf_left = utf_left - 2'd1;
                     if (utf_left == 0) begin
                        keep_code(utf_acc);
                        utf_acc = '0;
                     end
                  end
               end else if (b < 8'hE0) begin
                  utf_acc  = {16'd0, b[4:0]};
                  utf_left = 2'd1;
               end else if (b < 8'hF0) begin
                  utf_acc  = {17'd0, b[3:0]};
                  utf_left = 2'd2;
               end else if (b < 8'hF8) begin
                  utf_acc  = {18'd0, b[2:0]};
                  utf_left = 2'd3;
               end else begin
                  // invalid lead: abandon the partial character
                  utf_left = '0;
                  utf_acc  = '0;
               end
            end
         end
         MODE_UNICODE, MODE_DIRECT: begin
            if (it.mode == MODE_DIRECT)
               idx = it.code_point;
            else if (!cfg_has_table)
               idx = (it.code_point >= PRINT_LO && it.code_point <= PRINT_HI) ?
                     it.code_point : 0;
            else if (it.code_point > MAX_UNICODE || it.code_point >= MAP_DEPTH
                     || (it.code_point >= 21'hD800 && it.code_point <= 21'hDFFF))
               idx = 0;
            else
               idx = glyph_of_cp[it.code_point[CODE_BITS-1:0]];
            if (idx >= lim)
               idx = 0;
            w.glyph  = idx[8:0];
            w.loaded = !cfg_has_table || (cur_glyph >= lim);
            glyph_rsp_due.push_back(w);
         end
         default: ;   // mode three: nothing happens
      endcase
   endfunction

   // Random idle length: mostly none or short, a few long, and now and then
   // a quiet stretch with no idling at all
   function automatic int unsigned next_gap(inout int unsigned quiet_left);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if (r < 2) begin
         quiet_left = $urandom_range(30, 150);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic flag_mismatch(input string msg);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   // ---------------------------------------------------------------------------
   // Request driver: hold tvalid until the transaction is taken, predict it at
   // the accepting edge, then idle for a random gap before the next one.
   // ---------------------------------------------------------------------------
   glyph_req_type req_item;
   int unsigned   req_wait  = 0;
   int unsigned   req_quiet = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_glyph_map(req_item);
            n_accept++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_tvalid <= 1'b0;
            end else if (pending_req.size() > 0) begin
               req_item = pending_req.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {3'b000, req_item.code_point, req_item.data_byte};
               req_tuser  <= req_item.mode;
               req_wait = next_gap(req_quiet);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response monitor: check each accepted response against the oldest
   // outstanding lookup, and stall tready at random.
   // ---------------------------------------------------------------------------
   int unsigned rsp_stall = 0;
   int unsigned rsp_quiet = 0;

   always @(posedge clock) begin
      glyph_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (glyph_rsp_due.size() == 0) begin
               flag_mismatch($sformatf("response 0x%04h with no lookup outstanding", rsp_tdata));
            end else begin
               want = glyph_rsp_due.pop_front();
               n_checked++;
               if (rsp_tdata[8:0] !== want.glyph)
                  flag_mismatch($sformatf("glyph_index %0d, expected %0d",
                                          rsp_tdata[8:0], want.glyph));
               if (rsp_tdata[9] !== want.loaded)
                  flag_mismatch($sformatf("table_loaded %b, expected %b",
                                          rsp_tdata[9], want.loaded));
               if (rsp_tdata[15:10] !== 6'd0)
                  flag_mismatch($sformatf("pad bits 0x%02h, expected zero", rsp_tdata[15:10]));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
               rsp_stall = next_gap(rsp_quiet);
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic push_load(input logic [7:0] b);
      glyph_req_type it;
      it.mode       = MODE_LOAD;
      it.data_byte  = b;
      it.code_point = $urandom_range(0, 'h1FFFFF);   // don't-care field, toggle it anyway
      pending_req.push_back(it);
      pushed++;
   endtask

   task automatic push_lookup(input mode_type m, input logic [20:0] cp);
      glyph_req_type it;
      it.mode       = m;
      it.data_byte  = $urandom_range(0, 255);
      it.code_point = cp;
      pending_req.push_back(it);
      pushed++;
   endtask

   // Send the first keep bytes of an nb-byte UTF-8 form of cp (keep < nb truncates it)
   task automatic push_code(input logic [20:0] cp, input int unsigned nb,
                            input int unsigned keep);
      logic [7:0] seq [4];
      case (nb)
         1: seq[0] = {1'b0, cp[6:0]};
         2: begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = {2'b10, cp[5:0]};
         end
         3: begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = {2'b10, cp[11:6]};
            seq[2] = {2'b10, cp[5:0]};
         end
         default: begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = {2'b10, cp[17:12]};
            seq[2] = {2'b10, cp[11:6]};
            seq[3] = {2'b10, cp[5:0]};
         end
      endcase
      for (int i = 0; i < keep; i++)
         push_load(seq[i]);
   endtask

   // Wait until the block is idle: nothing queued, nothing in flight, every
   // response back; then allow for a trailing table write to land
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_req.size() != 0 || req_tvalid || glyph_rsp_due.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Setup cycle, access cycle; the register takes the value at the access edge
   task automatic csr_write(input logic reg_sel, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (reg_sel == CSR_GLYPH_COUNT)
         cfg_glyph_count = value[9:0];
      else
         cfg_has_table = value[0];
   endtask

   // Drain the previous phase, then program both registers
   task automatic begin_phase(input int unsigned count, input logic has_table);
      wait_idle();
      csr_write(CSR_GLYPH_COUNT, count);
      csr_write(CSR_HAS_TABLE, {31'd0, has_table});
   endtask

   // Mostly well-formed glyph entries (a few code points then the separator),
   // mixed with lookups, direct indexes, broken sequences and noise bytes
   task automatic add_random(input int unsigned n);
      int unsigned start;
      int unsigned r;
      int unsigned nb;
      logic [20:0] cp;
      start = pushed;
      while (pushed - start < n) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            repeat ($urandom_range(0, 2)) begin
               r = $urandom_range(0, 99);
               if (r < 35) begin
                  cp = $urandom_range(1, 'h7F);         nb = 1;
               end else if (r < 38) begin
                  cp = '0;                              nb = 1;   // null: never stored
               end else if (r < 63) begin
                  cp = $urandom_range('h80, 'h7FF);     nb = 2;
               end else if (r < 66) begin
                  cp = $urandom_range(0, 'h7F);         nb = 2;   // overlong form
               end else if (r < 83) begin
                  cp = $urandom_range('h800, 'hFFFF);   nb = 3;
               end else if (r < 88) begin
                  cp = $urandom_range('hD800, 'hDFFF);  nb = 3;   // surrogate
               end else if (r < 96) begin
                  cp = $urandom_range('h10000, 'h10FFFF); nb = 4;
               end else begin
                  cp = $urandom_range('h110000, 'h1FFFFF); nb = 4;
               end
               push_code(cp, nb, nb);
               recent_cp.push_back(cp);
               if (recent_cp.size() > 64)
                  void'(recent_cp.pop_front());
            end
            push_load(NEXT_GLYPH);
         end else if (r < 83) begin
            r = $urandom_range(0, 99);
            if (r < 40 && recent_cp.size() > 0)
               cp = recent_cp[$urandom_range(0, recent_cp.size() - 1)];
            else if (r < 55) cp = $urandom_range(0, 'h7F);
            else if (r < 65) cp = $urandom_range(0, 'h7FF);
            else if (r < 75) cp = $urandom_range(0, 'hFFFF);
            else if (r < 80) cp = $urandom_range('hD800, 'hDFFF);
            else if (r < 85) cp = $urandom_range('h10000, 'h10FFFF);
            else if (r < 90) cp = $urandom_range('h110000, 'h1FFFFF);
            else             cp = $urandom_range(0, 'h1FFFFF);
            push_lookup(MODE_UNICODE, cp);
         end else if (r < 91) begin
            r = $urandom_range(0, 99);
            if (r < 60)      cp = $urandom_range(0, 600);
            else if (r < 80) cp = cfg_glyph_count + $urandom_range(0, 2) - 1;
            else             cp = $urandom_range(0, 'h1FFFFF);
            push_lookup(MODE_DIRECT, cp);
         end else if (r < 97) begin
            // noise: a raw byte, or a character cut short by whatever follows
            if ($urandom_range(0, 1)) begin
               push_load($urandom_range(0, 255));
            end else begin
               nb = $urandom_range(2, 4);
               push_code($urandom_range(0, 'h1FFFFF), nb, $urandom_range(1, nb - 1));
            end
         end else begin
            push_lookup(MODE_NONE, $urandom_range(0, 'h1FFFFF));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      // Empty glyph, U+00E9, encoded surrogate, a stray, bad lead,
      // a 3-byte lead cut off by 'A', then the next separator
      logic [7:0] first_table [11] = '{8'hFF, 8'hC3, 8'hA9, 8'hED, 8'hA0, 8'h80,
                                       8'h80, 8'hFE, 8'hE2, 8'h41, 8'hFF};
      for (int i = 0; i < MAP_DEPTH; i++)
         glyph_of_cp[i] = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // No table, full range: identity map edges, direct index edges, mode
      // three, and a table byte that must be ignored
      begin_phase(512, 1'b0);
      push_lookup(MODE_UNICODE, 21'h1F);
      push_lookup(MODE_UNICODE, PRINT_LO);
      push_lookup(MODE_UNICODE, PRINT_HI);
      push_lookup(MODE_UNICODE, 21'h7F);
      push_lookup(MODE_UNICODE, 21'h1FFFFF);
      push_lookup(MODE_DIRECT, 21'd511);
      push_lookup(MODE_DIRECT, 21'd512);
      push_lookup(MODE_NONE, 21'd0);
      push_load(8'h41);
      add_random(150);

      // Zero glyphs: the table counts as loaded and every lookup gives zero
      begin_phase(0, 1'b1);
      add_random(100);

      // Four glyphs: a hand-built table, then check what stuck
      begin_phase(4, 1'b1);
      foreach (first_table[i])
         push_load(first_table[i]);
      push_lookup(MODE_UNICODE, 21'hE9);
      push_lookup(MODE_UNICODE, 21'h41);
      push_lookup(MODE_UNICODE, 21'hD800);
      push_lookup(MODE_UNICODE, 21'h110000);
      add_random(150);

      // Grow and shrink the count so loading stops, resumes and stops again
      begin_phase(64, 1'b1);
      add_random(300);
      begin_phase(1, 1'b1);
      add_random(100);
      begin_phase(200, 1'b1);
      add_random(300);
      begin_phase(512, 1'b1);
      add_random(400);
      begin_phase(90, 1'b0);
      add_random(150);
      begin_phase($urandom_range(300, 511), 1'b1);
      add_random(300);

      wait_idle();
      $display("Covered %0d requests (%0d table bytes) over nine register settings.",
               n_accept, n_loads);
      $display("Checked %0d lookup responses; table filled up to glyph %0d; %0d mismatches.",
               n_checked, cur_glyph, errors);
      if (errors == 0)
         $display("psf2_unicode_glyph_map test passed");
      else
         $display("psf2_unicode_glyph_map test failed");
      $finish;
   end

   // Give up well past the slowest legal run, clearing sweep included
   initial begin
      #4_000_000;
      $display("TIMEOUT: %0d of %0d requests taken, %0d responses outstanding",
               n_accept, pushed, glyph_rsp_due.size());
      $display("psf2_unicode_glyph_map test failed");
      $finish;
   end

endmodule
